/* design/ksl_pkg.sv */
// Shared types and constants for the key state latch.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ksl_pkg;

   localparam int KEY_W     = 8;
   localparam int KEY_CODES = 256;
   localparam int TURN_W    = 8;

   typedef logic [KEY_W-1:0]  key_code_type;
   typedef logic [TURN_W-1:0] turn_type;

   // request kinds carried on tuser
   typedef enum logic [1:0] {
      REQ_KEY   = 2'd0,
      REQ_TICK  = 2'd1,
      REQ_QUERY = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   // access to the key store; wr_full writes held and turn and marks the entry valid,
   // otherwise only the held bit of an already valid entry is written
   typedef struct packed {
      logic         rd_en;
      key_code_type rd_addr;
      logic         wr_en;
      logic         wr_full;
      key_code_type wr_addr;
      logic         wr_held;
      turn_type     wr_turn;
   } key_req_type;

   typedef struct packed {
      logic     held;
      turn_type turn;
   } key_rsp_type;

endpackage

/* design/ksl_key_store.sv */
// Per-key store: held bit and press turn for every key code, registered read.
// Depends on ksl_pkg. Valid flops give all-zero contents right after reset.
`timescale 1ns / 1ps

module ksl_key_store
   import ksl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  key_req_type key_req,
   output key_rsp_type key_rsp
);

   logic                 held_mem_ff [KEY_CODES];
   turn_type             turn_mem_ff [KEY_CODES];
   logic [KEY_CODES-1:0] valid_ff;
   logic                 held_q_ff;
   turn_type             turn_q_ff;
   logic                 valid_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         valid_q_ff <= 1'b0;
      end else begin
         if (key_req.wr_en && key_req.wr_full) begin
            valid_ff[key_req.wr_addr] <= 1'b1;
         end
         if (key_req.rd_en) begin
            valid_q_ff <= valid_ff[key_req.rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      // held-only writes to a never-written entry are dropped: it already reads zero
      if (key_req.wr_en && (key_req.wr_full || valid_ff[key_req.wr_addr])) begin
         held_mem_ff[key_req.wr_addr] <= key_req.wr_held;
      end
      if (key_req.wr_en && key_req.wr_full) begin
         turn_mem_ff[key_req.wr_addr] <= key_req.wr_turn;
      end
      if (key_req.rd_en) begin
         held_q_ff <= held_mem_ff[key_req.rd_addr];
         turn_q_ff <= turn_mem_ff[key_req.rd_addr];
      end
   end

   assign key_rsp.held = held_q_ff & valid_q_ff;
   assign key_rsp.turn = valid_q_ff ? turn_q_ff : '0;

endmodule

/* design/ksl_slot_store.sv */
// Deferred release slot list: one write and one registered read per cycle.
// Depends on ksl_pkg. Contents are undefined until written.
`timescale 1ns / 1ps

module ksl_slot_store
   import ksl_pkg::*;
#(
   parameter int SLOTS   = 10,
   parameter int SLOT_AW = 4
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [SLOT_AW-1:0] wr_addr,
   input  key_code_type       wr_data,
   input  logic               rd_en,
   input  logic [SLOT_AW-1:0] rd_addr,
   output key_code_type       rd_data
);

   key_code_type slot_mem_ff [SLOTS];
   key_code_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/key_state_latch_with_turn_release_unit.sv */
// Key state latch: tracks held state of 256 key codes; a release of a key pressed
// in the current turn is deferred to the next turn tick while a deferred slot is
// free, else it is cleared with the release event. One request is worked at a time
// by a sequencer around the key store; the time a request takes is set by the
// one-port key store (five modifier reads and one read of the requested code per
// result) and, on a turn tick, the slot walk. No clearing pass is needed after reset.
// A new request is taken while the last beat still waits.
// Depends on ksl_pkg, ksl_key_store and ksl_slot_store.
`timescale 1ns / 1ps

module key_state_latch_with_turn_release_unit
   import ksl_pkg::*;
#(
   parameter int RELEASE_SLOTS = 10
) (
   input  logic        clock,
   input  logic        reset,
   // request beat
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // scan_code[7:0], extended[8], key_up[9], zero pad
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   // result beat
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // alt_flag[0], control_flag[1], shift_flag[2],
                                    // last_pressed[10:3], queried_down[11], zero pad
   // register writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int CNT_W   = $clog2(RELEASE_SLOTS + 1);
   localparam int SLOT_AW = (RELEASE_SLOTS > 1) ? $clog2(RELEASE_SLOTS) : 1;

   localparam logic [2:0] CSR_LEFT_ALT    = 3'd0;
   localparam logic [2:0] CSR_RIGHT_ALT   = 3'd1;
   localparam logic [2:0] CSR_LEFT_CTRL   = 3'd2;
   localparam logic [2:0] CSR_LEFT_SHIFT  = 3'd3;
   localparam logic [2:0] CSR_RIGHT_SHIFT = 3'd4;

   // modifier read sequence: five modifiers, then the queried code
   localparam logic [2:0] FL_QUERY = 3'd5;
   localparam logic [2:0] FL_LAST  = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EV_RD,
      ST_EV_WR,
      ST_TICK,
      ST_FLAG,
      ST_DONE
   } state_type;

   state_type    state_ff, state_in;
   req_kind_type kind_ff, kind_in;
   key_code_type code_ff, code_in;
   logic         up_ff, up_in;
   turn_type     turn_ff, turn_in;
   key_code_type last_ff, last_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic         pend_ff, pend_in;
   logic [2:0]   fl_ff, fl_in;
   logic [5:0]   mods_ff, mods_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [15:0]  rsp_data_ff, rsp_data_in;

   key_code_type left_alt_ff, right_alt_ff, left_ctrl_ff, left_shift_ff, right_shift_ff;

   key_req_type  key_req;
   key_rsp_type  key_rsp;
   logic               slot_wr_en;
   logic [SLOT_AW-1:0] slot_wr_addr;
   logic               slot_rd_en;
   logic [SLOT_AW-1:0] slot_rd_addr;
   key_code_type       slot_rd_data;

   key_code_type flag_addr;
   key_code_type req_scan;
   logic         req_ext;
   logic         req_up;

   assign req_scan = req_tdata[7:0];
   assign req_ext  = req_tdata[8];
   assign req_up   = req_tdata[9];

   ksl_key_store u_key_store (
      .clock   (clock),
      .reset   (reset),
      .key_req (key_req),
      .key_rsp (key_rsp)
   );

   ksl_slot_store #(
      .SLOTS   (RELEASE_SLOTS),
      .SLOT_AW (SLOT_AW)
   ) u_slot_store (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (code_ff),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   always_comb begin
      case (fl_ff)
         3'd0:    flag_addr = left_alt_ff;
         3'd1:    flag_addr = right_alt_ff;
         3'd2:    flag_addr = left_ctrl_ff;
         3'd3:    flag_addr = left_shift_ff;
         3'd4:    flag_addr = right_shift_ff;
         default: flag_addr = code_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      code_in      = code_ff;
      up_in        = up_ff;
      turn_in      = turn_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      fl_in        = fl_ff;
      mods_in      = mods_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      key_req      = '0;
      slot_wr_en   = 1'b0;
      slot_wr_addr = cnt_ff[SLOT_AW-1:0];
      slot_rd_en   = 1'b0;
      slot_rd_addr = idx_ff[SLOT_AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_kind_type'(req_tuser);
               up_in   = req_up;
               fl_in   = 3'd0;
               case (req_kind_type'(req_tuser))
                  REQ_KEY: begin
                     code_in  = req_scan + {req_ext, 7'd0};
                     state_in = ST_EV_RD;
                  end
                  REQ_TICK: begin
                     code_in  = req_scan;
                     turn_in  = turn_ff + 1'b1;
                     idx_in   = '0;
                     pend_in  = 1'b0;
                     state_in = ST_TICK;
                  end
                  default: begin
                     code_in  = req_scan;
                     state_in = ST_FLAG;
                  end
               endcase
            end
         end

         ST_EV_RD: begin
            key_req.rd_en   = 1'b1;
            key_req.rd_addr = code_ff;
            state_in        = ST_EV_WR;
         end

         ST_EV_WR: begin
            key_req.wr_addr = code_ff;
            key_req.wr_full = 1'b1;
            if (up_ff) begin
               if (key_rsp.turn == turn_ff && cnt_ff < CNT_W'(RELEASE_SLOTS)) begin
                  slot_wr_en = 1'b1;
                  cnt_in     = cnt_ff + 1'b1;
               end else begin
                  key_req.wr_en   = 1'b1;
                  key_req.wr_held = 1'b0;
                  key_req.wr_turn = key_rsp.turn;
               end
            end else begin
               key_req.wr_en   = 1'b1;
               key_req.wr_held = 1'b1;
               key_req.wr_turn = turn_ff;
               last_in         = code_ff;
            end
            state_in = ST_FLAG;
         end

         ST_TICK: begin
            // slot read registered, held clear in the next cycle; overlapped across slots
            if (idx_ff < cnt_ff) begin
               slot_rd_en = 1'b1;
               idx_in     = idx_ff + 1'b1;
               pend_in    = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               key_req.wr_en   = 1'b1;
               key_req.wr_addr = slot_rd_data;
               key_req.wr_held = 1'b0;
            end
            if (idx_ff == cnt_ff && !pend_ff) begin
               cnt_in   = '0;
               state_in = ST_FLAG;
            end
         end

         ST_FLAG: begin
            if (fl_ff != FL_LAST) begin
               key_req.rd_en   = 1'b1;
               key_req.rd_addr = flag_addr;
            end
            if (fl_ff != 3'd0) begin
               mods_in[fl_ff - 3'd1] = key_rsp.held;
            end
            fl_in = fl_ff + 1'b1;
            if (fl_ff == FL_LAST) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0,
                               mods_ff[FL_QUERY] & (kind_ff == REQ_QUERY),
                               last_ff,
                               mods_ff[3] | mods_ff[4],
                               mods_ff[2],
                               mods_ff[0] | mods_ff[1]};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         turn_ff      <= '0;
         last_ff      <= '0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         fl_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         turn_ff      <= turn_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         fl_ff        <= fl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      code_ff     <= code_in;
      up_ff       <= up_in;
      mods_ff     <= mods_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_alt_ff    <= 8'd56;
         right_alt_ff   <= 8'd184;
         left_ctrl_ff   <= 8'd29;
         left_shift_ff  <= 8'd42;
         right_shift_ff <= 8'd54;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEFT_ALT:    left_alt_ff    <= csr_wdata;
            CSR_RIGHT_ALT:   right_alt_ff   <= csr_wdata;
            CSR_LEFT_CTRL:   left_ctrl_ff   <= csr_wdata;
            CSR_LEFT_SHIFT:  left_shift_ff  <= csr_wdata;
            CSR_RIGHT_SHIFT: right_shift_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(RELEASE_SLOTS))
      else $error("deferred count beyond slot count");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(key_req.rd_en && key_req.wr_en))
      else $error("key store read and write in one cycle");

   a_tick_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK && state_in == ST_FLAG) |=> (cnt_ff == '0))
      else $error("turn tick left deferred slots");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result beat raised outside completion");

endmodule

/* test/tb_key_state_latch_with_turn_release_unit.sv */
// Self-checking bench for key_state_latch_with_turn_release_unit: directed and random key
// events, turn ticks and queries against an in-bench key state tracker.
// Depends on ksl_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_key_state_latch_with_turn_release_unit
   import ksl_pkg::*;
();

   localparam int RELEASE_SLOTS = 10;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int REG_COUNT     = 5;

   localparam logic [2:0] REG_LEFT_ALT    = 3'd0;
   localparam logic [2:0] REG_RIGHT_ALT   = 3'd1;
   localparam logic [2:0] REG_LEFT_CTRL   = 3'd2;
   localparam logic [2:0] REG_LEFT_SHIFT  = 3'd3;
   localparam logic [2:0] REG_RIGHT_SHIFT = 3'd4;

   localparam key_code_type DEF_LEFT_ALT    = 8'd56;
   localparam key_code_type DEF_RIGHT_ALT   = 8'd184;
   localparam key_code_type DEF_LEFT_CTRL   = 8'd29;
   localparam key_code_type DEF_LEFT_SHIFT  = 8'd42;
   localparam key_code_type DEF_RIGHT_SHIFT = 8'd54;
   localparam key_code_type EXT_OFFSET      = 8'h80;

   typedef struct packed {
      req_kind_type kind;
      key_code_type scan;
      logic         ext;
      logic         up;
   } key_beat_type;

   typedef struct packed {
      logic         alt;
      logic         ctrl;
      logic         shift;
      key_code_type last;
      logic         down;
   } key_result_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PATTERN
   } ready_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // scan_code[7:0], extended[8], key_up[9], zero pad
   logic [1:0]  req_tuser = '0;   // req_type[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // alt[0], control[1], shift[2], last[10:3], queried[11]
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   key_state_latch_with_turn_release_unit #(
      .RELEASE_SLOTS(RELEASE_SLOTS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // tracker state
   bit           held_m [KEY_CODES];
   key_code_type turn_m [KEY_CODES];
   key_code_type slot_m [RELEASE_SLOTS];
   int unsigned  slot_cnt;
   turn_type     turn_no;
   key_code_type last_key;
   key_code_type cfg_m [REG_COUNT];

   key_beat_type   pending_beats [$];
   key_result_type expected_results [$];
   key_code_type   cfg_set [REG_COUNT];
   key_code_type   extra_codes [3];

   int  err_cnt = 0;
   int  cycle_cnt = 0;
   bit  req_fire = 1'b0;
   int  burst_left = 1;
   int  gap_left = 0;
   int  stall_timer = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   logic [15:0] stall_mask = 16'hFFFF;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) cycle_cnt <= cycle_cnt + 1;

   initial begin : watchdog
      while (cycle_cnt < CYCLE_LIMIT) @(posedge clock);
      $display("tb_key_state_latch_with_turn_release_unit: errors");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      err_cnt++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   task automatic reset_key_model();
      for (int i = 0; i < KEY_CODES; i++) begin
         held_m[i] = 1'b0;
         turn_m[i] = '0;
      end
      slot_cnt = 0;
      turn_no  = '0;
      last_key = '0;
      cfg_m[REG_LEFT_ALT]    = DEF_LEFT_ALT;
      cfg_m[REG_RIGHT_ALT]   = DEF_RIGHT_ALT;
      cfg_m[REG_LEFT_CTRL]   = DEF_LEFT_CTRL;
      cfg_m[REG_LEFT_SHIFT]  = DEF_LEFT_SHIFT;
      cfg_m[REG_RIGHT_SHIFT] = DEF_RIGHT_SHIFT;
   endtask

   function automatic key_result_type advance_key_state(input key_beat_type b);
      key_result_type res;
      key_code_type   code;
      res.down = 1'b0;
      code = b.scan + (b.ext ? EXT_OFFSET : 8'h00);
      case (b.kind)
         REQ_KEY: begin
            if (b.up) begin
               // same-turn release waits for the next tick while a slot is free
               if (turn_m[code] == turn_no && slot_cnt < RELEASE_SLOTS) begin
                  slot_m[slot_cnt] = code;
                  slot_cnt++;
               end else begin
                  held_m[code] = 1'b0;
               end
            end else begin
               turn_m[code] = turn_no;
               held_m[code] = 1'b1;
               last_key = code;
            end
         end
         REQ_TICK: begin
            turn_no = turn_no + 8'd1;
            for (int i = 0; i < slot_cnt; i++) held_m[slot_m[i]] = 1'b0;
            slot_cnt = 0;
         end
         REQ_QUERY: res.down = held_m[b.scan];
         default: ;
      endcase
      res.alt   = held_m[cfg_m[REG_LEFT_ALT]] | held_m[cfg_m[REG_RIGHT_ALT]];
      res.ctrl  = held_m[cfg_m[REG_LEFT_CTRL]];
      res.shift = held_m[cfg_m[REG_LEFT_SHIFT]] | held_m[cfg_m[REG_RIGHT_SHIFT]];
      res.last  = last_key;
      return res;
   endfunction

   // monitor: register writes, result checks, prediction of accepted requests
   always @(posedge clock) begin : monitor
      key_result_type got, want;
      key_beat_type   taken;
      if (reset) begin
         reset_key_model();
         req_fire = 1'b0;
      end else begin
         req_fire = req_tvalid && req_tready;
         if (csr_we && csr_index < REG_COUNT) cfg_m[csr_index] = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got.alt   = rsp_tdata[0];
            got.ctrl  = rsp_tdata[1];
            got.shift = rsp_tdata[2];
            got.last  = rsp_tdata[10:3];
            got.down  = rsp_tdata[11];
            if (expected_results.size() == 0) begin
               report_mismatch("result beat with nothing outstanding");
            end else begin
               want = expected_results.pop_front();
               check_field("alt_flag", int'(got.alt), int'(want.alt));
               check_field("control_flag", int'(got.ctrl), int'(want.ctrl));
               check_field("shift_flag", int'(got.shift), int'(want.shift));
               check_field("last_pressed", int'(got.last), int'(want.last));
               check_field("queried_down", int'(got.down), int'(want.down));
            end
         end
         if (req_fire) begin
            taken.kind = req_kind_type'(req_tuser);
            taken.scan = req_tdata[7:0];
            taken.ext  = req_tdata[8];
            taken.up   = req_tdata[9];
            expected_results.push_back(advance_key_state(taken));
         end
      end
   end

   // request driver: bursts with random gaps
   always @(negedge clock) begin : driver
      key_beat_type b;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         // beat still waiting, hold
      end else if (gap_left > 0) begin
         gap_left   <= gap_left - 1;
         req_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
         b = pending_beats.pop_front();
         req_tdata  <= {6'd0, b.up, b.ext, b.scan};
         req_tuser  <= b.kind;
         req_tvalid <= 1'b1;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // result backpressure; the ready mode is picked at random whenever the stall timer runs out
   always @(negedge clock) begin : receiver
      if (stall_timer == 0) begin
         stall_timer <= 200;
         ready_mode  <= ready_mode_type'($urandom_range(0, 2));
         stall_mask  <= 16'($urandom) | 16'h0001;
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_RANDOM: rsp_tready <= ($urandom_range(0, 9) < 6);
         default:      rsp_tready <= stall_mask[cycle_cnt % 16];
      endcase
   end

   task automatic add_beat(input req_kind_type kind, input key_code_type scan,
                           input logic ext, input logic up);
      key_beat_type b;
      b.kind = kind;
      b.scan = scan;
      b.ext  = ext;
      b.up   = up;
      pending_beats.push_back(b);
   endtask

   // key event on a code, reached with or without the extended offset
   task automatic add_key(input key_code_type code, input logic up);
      logic ext;
      ext = 1'($urandom_range(0, 1));
      add_beat(REQ_KEY, code - (ext ? EXT_OFFSET : 8'h00), ext, up);
   endtask

   function automatic key_code_type pick_code();
      int r;
      r = $urandom_range(0, 7);
      if (r < REG_COUNT) return cfg_set[r];
      return extra_codes[r - REG_COUNT];
   endfunction

   task automatic add_random_beats(input int count);
      int pushed, r;
      key_code_type c, d;
      pushed = 0;
      while (pushed < count) begin
         r = $urandom_range(0, 99);
         c = pick_code();
         if (r < 35) begin
            add_key(c, 1'($urandom_range(0, 1)));
            pushed += 1;
         end else if (r < 45) begin
            add_key(c, 1'b0);
            add_key(c, 1'b1);
            pushed += 2;
         end else if (r < 60) begin
            add_beat(REQ_TICK, key_code_type'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            pushed += 1;
         end else if (r < 85) begin
            add_beat(REQ_QUERY,
                     ($urandom_range(0, 3) == 0) ? key_code_type'($urandom_range(0, 255)) : c,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            pushed += 1;
         end else if (r < 90) begin
            add_beat(REQ_NONE, key_code_type'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            pushed += 1;
         end else if (r < 95) begin
            add_beat(REQ_KEY, key_code_type'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            pushed += 1;
         end else begin
            // more same-turn releases than slots
            d = pick_code();
            add_key(c, 1'b0);
            add_key(d, 1'b0);
            repeat (RELEASE_SLOTS + 1) add_key($urandom_range(0, 1) ? c : d, 1'b1);
            add_beat(REQ_QUERY, c, 1'b0, 1'b0);
            pushed += RELEASE_SLOTS + 4;
         end
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // writes cfg_set to the five registers, then junk to the unused indexes
   task automatic program_regs();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= (i < REG_COUNT) ? cfg_set[i] : key_code_type'($urandom_range(0, 255));
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      key_code_type same;
      key_code_type wrap_code;
      cfg_set[REG_LEFT_ALT]    = DEF_LEFT_ALT;
      cfg_set[REG_RIGHT_ALT]   = DEF_RIGHT_ALT;
      cfg_set[REG_LEFT_CTRL]   = DEF_LEFT_CTRL;
      cfg_set[REG_LEFT_SHIFT]  = DEF_LEFT_SHIFT;
      cfg_set[REG_RIGHT_SHIFT] = DEF_RIGHT_SHIFT;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part on reset register values
      add_beat(REQ_QUERY, 8'h00, 1'b0, 1'b0);
      add_beat(REQ_QUERY, 8'hFF, 1'b1, 1'b1);   // ext and up ignored on query
      add_beat(REQ_KEY, DEF_LEFT_ALT, 1'b0, 1'b0);
      add_beat(REQ_KEY, 8'h38, 1'b1, 1'b0);     // extended: right alt
      add_beat(REQ_KEY, 8'hFF, 1'b1, 1'b0);     // extended offset wraps
      add_beat(REQ_KEY, DEF_LEFT_CTRL, 1'b0, 1'b0);
      add_beat(REQ_KEY, DEF_LEFT_SHIFT, 1'b0, 1'b0);
      add_beat(REQ_KEY, DEF_LEFT_SHIFT, 1'b0, 1'b1);   // deferred, still held
      add_beat(REQ_QUERY, DEF_LEFT_SHIFT, 1'b0, 1'b0);
      add_beat(REQ_TICK, 8'hA5, 1'b1, 1'b1);
      add_beat(REQ_QUERY, DEF_LEFT_SHIFT, 1'b0, 1'b0);
      add_beat(REQ_KEY, DEF_LEFT_ALT, 1'b0, 1'b1);     // older turn, clears now
      add_beat(REQ_NONE, 8'h5A, 1'b1, 1'b1);
      // fill every slot with one code, then one more release
      add_beat(REQ_KEY, 8'h10, 1'b0, 1'b0);
      add_beat(REQ_KEY, 8'h11, 1'b0, 1'b0);
      repeat (RELEASE_SLOTS) add_beat(REQ_KEY, 8'h10, 1'b0, 1'b1);
      add_beat(REQ_KEY, 8'h11, 1'b0, 1'b1);
      add_beat(REQ_QUERY, 8'h11, 1'b0, 1'b0);
      add_beat(REQ_QUERY, 8'h10, 1'b0, 1'b0);
      add_beat(REQ_TICK, 8'h00, 1'b0, 1'b0);
      add_beat(REQ_QUERY, 8'h10, 1'b0, 1'b0);
      wait_idle();

      // random part over several register settings
      for (int phase = 0; phase < 5; phase++) begin
         same = key_code_type'($urandom_range(0, 255));
         for (int i = 0; i < REG_COUNT; i++) begin
            case (phase)
               0:       cfg_set[i] = 8'h00;
               1:       cfg_set[i] = 8'hFF;
               2:       cfg_set[i] = key_code_type'($urandom_range(0, 255));
               3:       cfg_set[i] = same;
               default: cfg_set[i] = (i == 0) ? DEF_LEFT_ALT : (i == 1) ? DEF_RIGHT_ALT :
                                      (i == 2) ? DEF_LEFT_CTRL : (i == 3) ? DEF_LEFT_SHIFT :
                                      DEF_RIGHT_SHIFT;
            endcase
         end
         for (int i = 0; i < 3; i++) extra_codes[i] = key_code_type'($urandom_range(0, 255));
         program_regs();
         add_random_beats(45);
         wait_idle();
      end

      // turn counter wraps: a press 256 ticks back counts as this turn
      wrap_code = key_code_type'($urandom_range(0, 255));
      add_key(wrap_code, 1'b0);
      repeat (256) add_beat(REQ_TICK, key_code_type'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      add_key(wrap_code, 1'b1);
      add_beat(REQ_QUERY, wrap_code, 1'b0, 1'b0);
      add_beat(REQ_TICK, 8'h00, 1'b0, 1'b0);
      add_beat(REQ_QUERY, wrap_code, 1'b0, 1'b0);
      wait_idle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) report_mismatch("results still outstanding at end");
      if (err_cnt == 0)
         $display("tb_key_state_latch_with_turn_release_unit: clean");
      else
         $display("tb_key_state_latch_with_turn_release_unit: errors");
      $finish;
   end

endmodule

/* key_state_latch_with_turn_release_unit.f */
design/ksl_pkg.sv
design/ksl_key_store.sv
design/ksl_slot_store.sv
design/key_state_latch_with_turn_release_unit.sv
test/tb_key_state_latch_with_turn_release_unit.sv
